/* sv/sleb_pkg.sv */
// shared types and constants for the single line edit buffer
// no dependencies
package sleb_pkg;

  localparam int unsigned TEXT_DEPTH_DEF  = 256;
  localparam int unsigned SCRAP_DEPTH_DEF = 256;

  localparam logic [3:0] OP_KEY        = 4'd0;
  localparam logic [3:0] OP_CLICK      = 4'd1;
  localparam logic [3:0] OP_SET_SELECT = 4'd2;
  localparam logic [3:0] OP_CUT        = 4'd3;
  localparam logic [3:0] OP_COPY       = 4'd4;
  localparam logic [3:0] OP_PASTE      = 4'd5;
  localparam logic [3:0] OP_CLEAR      = 4'd6;
  localparam logic [3:0] OP_START_LOAD = 4'd7;
  localparam logic [3:0] OP_LOAD_CHAR  = 4'd8;
  localparam logic [3:0] OP_ACTIVATE   = 4'd9;
  localparam logic [3:0] OP_DEACTIVATE = 4'd10;
  localparam logic [3:0] OP_TICK       = 4'd11;
  localparam logic [3:0] OP_READ_CHAR  = 4'd12;

  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_LEFT      = 8'h1C;
  localparam logic [7:0] KEY_RIGHT     = 8'h1D;
  localparam logic [7:0] KEY_HOME      = 8'h1E;
  localparam logic [7:0] KEY_END       = 8'h1F;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NOP      = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [7:0] BLINK_RESET = 8'd30;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_ROT,
    MODE_DEL,
    MODE_INS
  } sleb_mode_e;

  typedef struct packed {
    sleb_mode_e mode;
    logic [7:0] din;
  } sleb_cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TROT,
    ST_SALIGN,
    ST_DEL,
    ST_INS,
    ST_SREST,
    ST_DONE
  } sleb_state_e;

endpackage

/* sv/sleb_cell.sv */
// one character cell of a shifting row, used for the text and the scrap
// depends on sleb_pkg
module sleb_cell import sleb_pkg::*; #(
  parameter int unsigned PW    = 9,
  parameter int unsigned INDEX = 0
) (
  input  logic           clk_i,
  input  sleb_cell_ctl_t ctl_i,
  input  logic [PW-1:0]  pos_i,
  input  logic [7:0]     prev_i,
  input  logic [7:0]     next_i,
  output logic [7:0]     data_o
);

  localparam logic [PW-1:0] MyIdx = PW'(INDEX);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.mode)
      MODE_ROT: data_d = next_i;
      MODE_DEL: begin
        if (MyIdx >= pos_i) data_d = next_i;
      end
      MODE_INS: begin
        if (MyIdx > pos_i) data_d = prev_i;
        else if (MyIdx == pos_i) data_d = ctl_i.din;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* sv/single_line_edit_buffer.sv */
// single line edit buffer: sequencer, scalar state and two rows of cells
// depends on sleb_pkg and sleb_cell; an op without data moves goes straight to its result;
// otherwise the sequencer deletes and then inserts, read_char rotates the text, copy rotates
// the text and then aligns the scrap, cut adds the delete, paste inserts while rotating the
// scrap and then restores it (deleting a replaced selection first); one item at a time, the
// next item accepted once the result is valid; reset clears control state, cells undefined until written
module single_line_edit_buffer import sleb_pkg::*; #(
  parameter int unsigned TEXT_DEPTH  = TEXT_DEPTH_DEF,
  parameter int unsigned SCRAP_DEPTH = SCRAP_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], position_a[16:8], position_b[25:17], extend_select[26]
  input  logic [31:0] s_axis_tdata,
  // opcode[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], text_len[16:8], sel_first[25:17], sel_last[34:26],
  // caret_on[35], redraw[36], scrap_len[45:37]
  output logic [47:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int unsigned LW  = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned LWS = $clog2(SCRAP_DEPTH + 1);
  localparam int unsigned FW  = ((LW > LWS) ? LW : LWS) + 1;
  localparam int unsigned PW  = (LW > 9) ? LW : 9;
  localparam int unsigned MD  = (TEXT_DEPTH > SCRAP_DEPTH) ? TEXT_DEPTH : SCRAP_DEPTH;
  localparam int unsigned CW  = $clog2(MD + 1);

  // input fields
  logic [3:0] op;
  logic [7:0] ch;
  logic [8:0] pa, pb;
  logic       ext;
  assign op  = s_axis_tuser;
  assign ch  = s_axis_tdata[7:0];
  assign pa  = s_axis_tdata[16:8];
  assign pb  = s_axis_tdata[25:17];
  assign ext = s_axis_tdata[26];

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // scalar state
  logic [LW-1:0]  len_q, len_d, ss_q, ss_d, se_q, se_d;
  logic [LWS-1:0] slen_q, slen_d;
  logic           caret_q, caret_d, act_q, act_d;
  logic [7:0]     bcnt_q, bcnt_d, period_q;

  // plan of the data moves
  logic [CW-1:0]  del_n_d, del_n_q, ins_n_d, ins_n_q;
  logic [LW-1:0]  del_p_d, del_p_q, ins_p_d, ins_p_q;
  logic [LW-1:0]  cs_q, ce_q;
  logic [PW-1:0]  pa_q;
  logic           rd_ok_d, rd_ok_q;
  logic           f_copy_d, f_copy_q, f_read_d, f_read_q, f_paste_d, f_paste_q;
  logic [7:0]     ch_q;

  // result snapshot
  logic [1:0] status_d, res_status_q;
  logic       redraw_d, res_redraw_q;
  logic [7:0] res_rd_q;

  logic [LW-1:0] sel_n, p_click, a_cl, b_cl, p_move;
  logic [PW-1:0] pa_w, pb_w;
  logic          fits1, fitsp;
  logic [7:0]    bnext;

  always_comb begin
    pa_w  = PW'(pa);
    pb_w  = PW'(pb);
    sel_n = se_q - ss_q;
    fits1 = (FW'(len_q) - FW'(sel_n) + FW'(1)) <= FW'(TEXT_DEPTH);
    fitsp = (FW'(len_q) - FW'(sel_n) + FW'(slen_q)) <= FW'(TEXT_DEPTH);
    p_click = (pa_w > PW'(len_q)) ? len_q : LW'(pa_w);
    a_cl    = p_click;
    b_cl    = (pb_w > PW'(len_q)) ? len_q : LW'(pb_w);
    bnext   = bcnt_q + 8'd1;
    p_move  = '0;

    len_d = len_q; ss_d = ss_q; se_d = se_q; slen_d = slen_q;
    caret_d = caret_q; act_d = act_q; bcnt_d = bcnt_q;
    status_d = STATUS_DONE; redraw_d = 1'b0;
    del_n_d = '0; del_p_d = ss_q; ins_n_d = '0; ins_p_d = ss_q;
    f_copy_d = 1'b0; f_read_d = 1'b0; f_paste_d = 1'b0;
    rd_ok_d = pa_w < PW'(len_q);

    case (op)
      OP_KEY: begin
        redraw_d = 1'b1;
        case (ch)
          KEY_BACKSPACE: begin
            if (ss_q != se_q) begin
              del_n_d = CW'(sel_n);
              len_d   = len_q - sel_n;
              se_d    = ss_q;
            end else if (ss_q != '0) begin
              del_n_d = CW'(1);
              del_p_d = ss_q - LW'(1);
              len_d   = len_q - LW'(1);
              ss_d    = ss_q - LW'(1);
              se_d    = ss_q - LW'(1);
            end
          end
          KEY_LEFT: begin
            p_move = (ss_q != se_q) ? ss_q : ((ss_q != '0) ? ss_q - LW'(1) : '0);
            ss_d = p_move; se_d = p_move;
          end
          KEY_RIGHT: begin
            p_move = (ss_q != se_q) ? se_q : ((se_q < len_q) ? se_q + LW'(1) : len_q);
            ss_d = p_move; se_d = p_move;
          end
          KEY_HOME: begin
            ss_d = '0; se_d = '0;
          end
          KEY_END: begin
            ss_d = len_q; se_d = len_q;
          end
          default: begin
            if (!fits1) begin
              status_d = STATUS_OVERFLOW;
              redraw_d = 1'b0;
            end else begin
              del_n_d = CW'(sel_n);
              ins_n_d = CW'(1);
              len_d   = LW'(FW'(len_q) - FW'(sel_n) + FW'(1));
              ss_d    = ss_q + LW'(1);
              se_d    = ss_q + LW'(1);
            end
          end
        endcase
        if (status_d == STATUS_DONE) begin
          caret_d = 1'b1; bcnt_d = '0;
        end
      end
      OP_CLICK: begin
        if (ext) begin
          if (p_click < ss_q) ss_d = p_click;
          else se_d = p_click;
        end else begin
          ss_d = p_click; se_d = p_click;
        end
        caret_d = 1'b1; bcnt_d = '0; redraw_d = 1'b1;
      end
      OP_SET_SELECT: begin
        ss_d = (a_cl > b_cl) ? b_cl : a_cl;
        se_d = (a_cl > b_cl) ? a_cl : b_cl;
        redraw_d = 1'b1;
      end
      OP_CUT, OP_COPY: begin
        if (ss_q == se_q) begin
          status_d = STATUS_NOP;
        end else if (FW'(sel_n) > FW'(SCRAP_DEPTH)) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          f_copy_d = 1'b1;
          slen_d   = LWS'(sel_n);
          if (op == OP_CUT) begin
            del_n_d = CW'(sel_n);
            len_d   = len_q - sel_n;
            se_d    = ss_q;
            caret_d = 1'b1; bcnt_d = '0; redraw_d = 1'b1;
          end
        end
      end
      OP_PASTE: begin
        if (slen_q == '0) begin
          status_d = STATUS_NOP;
        end else if (!fitsp) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          del_n_d   = CW'(sel_n);
          ins_n_d   = CW'(slen_q);
          f_paste_d = 1'b1;
          len_d     = LW'(FW'(len_q) - FW'(sel_n) + FW'(slen_q));
          ss_d      = LW'(FW'(ss_q) + FW'(slen_q));
          se_d      = LW'(FW'(ss_q) + FW'(slen_q));
          caret_d = 1'b1; bcnt_d = '0; redraw_d = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (ss_q == se_q) begin
          status_d = STATUS_NOP;
        end else begin
          del_n_d = CW'(sel_n);
          len_d   = len_q - sel_n;
          se_d    = ss_q;
          caret_d = 1'b1; bcnt_d = '0; redraw_d = 1'b1;
        end
      end
      OP_START_LOAD: begin
        len_d = '0; ss_d = '0; se_d = '0; redraw_d = 1'b1;
      end
      OP_LOAD_CHAR: begin
        if (FW'(len_q) >= FW'(TEXT_DEPTH)) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          ins_n_d = CW'(1);
          ins_p_d = len_q;
          len_d   = len_q + LW'(1);
          ss_d    = len_q + LW'(1);
          se_d    = len_q + LW'(1);
          redraw_d = 1'b1;
        end
      end
      OP_ACTIVATE: begin
        act_d = 1'b1; caret_d = 1'b1; bcnt_d = '0; redraw_d = 1'b1;
      end
      OP_DEACTIVATE: begin
        act_d = 1'b0; redraw_d = 1'b1;
      end
      OP_TICK: begin
        if (!act_q) begin
          status_d = STATUS_NOP;
        end else if (bnext >= period_q) begin
          caret_d  = !caret_q;
          bcnt_d   = '0;
          redraw_d = (ss_q == se_q);
        end else begin
          bcnt_d = bnext;
        end
      end
      OP_READ_CHAR: f_read_d = 1'b1;
      default: status_d = STATUS_NOP;
    endcase
  end

  // sequencer
  sleb_state_e   st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] pos_q, pos_d;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (f_read_d || f_copy_d) begin
            st_d = ST_TROT; cnt_d = CW'(TEXT_DEPTH); pos_d = '0;
          end else if (del_n_d != '0) begin
            st_d = ST_DEL; cnt_d = del_n_d; pos_d = del_p_d;
          end else if (ins_n_d != '0) begin
            st_d = ST_INS; cnt_d = ins_n_d; pos_d = ins_p_d;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_TROT: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1); pos_d = pos_q + LW'(1);
        end else if (f_copy_q) begin
          st_d = ST_SALIGN; cnt_d = CW'(SCRAP_DEPTH) - CW'(ce_q - cs_q);
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_SALIGN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1);
        end else if (del_n_q != '0) begin
          st_d = ST_DEL; cnt_d = del_n_q; pos_d = del_p_q;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_DEL: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1);
        end else if (ins_n_q != '0) begin
          st_d = ST_INS; cnt_d = ins_n_q; pos_d = ins_p_q;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_INS: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1); pos_d = pos_q + LW'(1);
        end else if (f_paste_q) begin
          st_d = ST_SREST; cnt_d = CW'(SCRAP_DEPTH) - ins_n_q;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_SREST: begin
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
        else st_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // cell row controls
  logic [7:0]     t_data [TEXT_DEPTH];
  logic [7:0]     s_data [SCRAP_DEPTH];
  sleb_cell_ctl_t t_ctl, s_ctl;
  logic           s_push, run, in_sel, rd_hit;

  always_comb begin
    run    = cnt_q != '0;
    in_sel = (pos_q >= cs_q) && (pos_q < ce_q);
    rd_hit = (st_q == ST_TROT) && run && f_read_q && rd_ok_q && (PW'(pos_q) == pa_q);
    t_ctl  = '{mode: MODE_HOLD, din: ch_q};
    s_ctl  = '{mode: MODE_HOLD, din: 8'h00};
    s_push = 1'b0;
    if (f_paste_q) t_ctl.din = s_data[0];
    case (st_q)
      ST_TROT: begin
        if (run) begin
          t_ctl.mode = MODE_ROT;
          if (f_copy_q && in_sel) begin
            s_ctl.mode = MODE_ROT; s_push = 1'b1;
          end
        end
      end
      ST_SALIGN, ST_SREST: begin
        if (run) s_ctl.mode = MODE_ROT;
      end
      ST_DEL: begin
        if (run) t_ctl.mode = MODE_DEL;
      end
      ST_INS: begin
        if (run) begin
          t_ctl.mode = MODE_INS;
          if (f_paste_q) s_ctl.mode = MODE_ROT;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < TEXT_DEPTH; i++) begin : g_text
    localparam int unsigned Nx = (i + 1) % TEXT_DEPTH;
    localparam int unsigned Pv = (i == 0) ? 0 : i - 1;
    sleb_cell #(.PW(LW), .INDEX(i)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (t_ctl),
      .pos_i  (pos_q),
      .prev_i (t_data[Pv]),
      .next_i (t_data[Nx]),
      .data_o (t_data[i])
    );
  end

  for (genvar j = 0; j < SCRAP_DEPTH; j++) begin : g_scrap
    localparam int unsigned Nx = (j + 1) % SCRAP_DEPTH;
    localparam int unsigned Pv = (j == 0) ? 0 : j - 1;
    logic [7:0] nxt;
    if (j == SCRAP_DEPTH - 1) begin : g_top
      assign nxt = s_push ? t_data[0] : s_data[0];
    end else begin : g_mid
      assign nxt = s_data[Nx];
    end
    sleb_cell #(.PW(LWS), .INDEX(j)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (s_ctl),
      .pos_i  ('0),
      .prev_i (s_data[Pv]),
      .next_i (nxt),
      .data_o (s_data[j])
    );
  end

  // registers
  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic [1:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      ss_q      <= '0;
      se_q      <= '0;
      slen_q    <= '0;
      caret_q   <= 1'b1;
      act_q     <= 1'b0;
      bcnt_q    <= '0;
      period_q  <= BLINK_RESET;
      f_copy_q  <= 1'b0;
      f_read_q  <= 1'b0;
      f_paste_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (in_acc) begin
        len_q     <= len_d;
        ss_q      <= ss_d;
        se_q      <= se_d;
        slen_q    <= slen_d;
        caret_q   <= caret_d;
        act_q     <= act_d;
        bcnt_q    <= bcnt_d;
        f_copy_q  <= f_copy_d;
        f_read_q  <= f_read_d;
        f_paste_q <= f_paste_d;
      end
      if (st_q == ST_DONE && st_d == ST_IDLE) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      del_n_q      <= del_n_d;
      del_p_q      <= del_p_d;
      ins_n_q      <= ins_n_d;
      ins_p_q      <= ins_p_d;
      cs_q         <= ss_q;
      ce_q         <= se_q;
      pa_q         <= pa_w;
      rd_ok_q      <= rd_ok_d;
      ch_q         <= ch;
      res_status_q <= status_d;
      res_redraw_q <= redraw_d;
      res_rd_q     <= '0;
    end else if (rd_hit) begin
      res_rd_q <= t_data[0];
    end
    if (st_q == ST_DONE && st_d == ST_IDLE) begin
      m_user_q <= res_status_q;
      m_data_q <= {2'b00, 9'(slen_q), res_redraw_q, caret_q, 9'(se_q), 9'(ss_q),
                   9'(len_q), res_rd_q};
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_sel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ss_q <= se_q) && (se_q <= len_q))
    else $error("selection out of order");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FW'(len_q) <= FW'(TEXT_DEPTH)) && (FW'(slen_q) <= FW'(SCRAP_DEPTH)))
    else $error("length beyond depth");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("accepted while busy");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && st_d == ST_IDLE) |=> m_axis_tvalid)
    else $error("result not presented");

endmodule

/* tb/tb_top.sv */
// testbench for single_line_edit_buffer: a queue-fed driver, a stalling receiver,
// an in-bench prediction of the line, selection, scrap and caret, and a checker
// depends on sleb_pkg and the single_line_edit_buffer rtl
module tb_top;
  import sleb_pkg::*;

  localparam int DEPTH = 256;
  localparam int WATCH_LIMIT = 6000;

  typedef struct {
    logic [3:0] op;
    logic [7:0] ch;
    logic [8:0] pa;
    logic [8:0] pb;
    logic       ext;
    int         gap;
    bit         drain;
  } edit_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rdata;
    logic [8:0] len;
    logic [8:0] sfirst;
    logic [8:0] slast;
    logic       caret;
    logic       redraw;
    logic [8:0] slen;
  } snapshot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;

  single_line_edit_buffer dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  edit_item_t pending_q[$];
  snapshot_t  snapshot_q[$];
  edit_item_t cur_item;
  bit         have_item = 0;
  bit         sent = 0;
  bit         got = 0;
  int         gap_cnt = 0;
  int         gap_max = 0;
  int         stall_max = 0;
  int         rx_wait = 0;
  int         hold_cnt = 0;
  bit         hold_req = 0;
  int         idle_cycles = 0;
  int         fail_cnt = 0;

  // shadow of the block state
  byte unsigned line_mem[DEPTH];
  byte unsigned scrap_mem[DEPTH];
  byte unsigned src_buf[DEPTH];
  int unsigned  line_len, sel_a, sel_b, scrap_len, blink_cnt, blink_per;
  bit           caret_vis, active;

  function automatic void replace_range(int unsigned s, int unsigned e, int unsigned n);
    byte unsigned old[DEPTH];
    int unsigned tail;
    old = line_mem;
    tail = line_len - e;
    for (int i = 0; i < tail; i++) line_mem[s + n + i] = old[e + i];
    for (int i = 0; i < n; i++) line_mem[s + i] = src_buf[i];
    line_len = s + n + tail;
    sel_a = s + n;
    sel_b = s + n;
  endfunction

  function automatic bit room_for(int unsigned n);
    return line_len - (sel_b - sel_a) + n <= DEPTH;
  endfunction

  function automatic void edit_predict(edit_item_t it);
    snapshot_t r;
    int unsigned s, e, p, q, per;
    bit restart;
    r = '0;
    s = sel_a;
    e = sel_b;
    restart = 0;
    case (it.op)
      OP_KEY: begin
        r.redraw = 1'b1;
        restart = 1;
        if (it.ch == KEY_BACKSPACE) begin
          if (s != e) replace_range(s, e, 0);
          else if (s > 0) replace_range(s - 1, s, 0);
        end else if (it.ch == KEY_LEFT) begin
          p = (s != e) ? s : (s > 0 ? s - 1 : 0);
          sel_a = p; sel_b = p;
        end else if (it.ch == KEY_RIGHT) begin
          p = (s != e) ? e : (e < line_len ? e + 1 : line_len);
          sel_a = p; sel_b = p;
        end else if (it.ch == KEY_HOME) begin
          sel_a = 0; sel_b = 0;
        end else if (it.ch == KEY_END) begin
          sel_a = line_len; sel_b = line_len;
        end else if (!room_for(1)) begin
          r.status = STATUS_OVERFLOW;
          r.redraw = 1'b0;
          restart = 0;
        end else begin
          src_buf[0] = it.ch;
          replace_range(s, e, 1);
        end
      end
      OP_CLICK: begin
        p = (it.pa > line_len) ? line_len : it.pa;
        if (it.ext) begin
          if (p < sel_a) sel_a = p;
          else sel_b = p;
        end else begin
          sel_a = p; sel_b = p;
        end
        restart = 1;
        r.redraw = 1'b1;
      end
      OP_SET_SELECT: begin
        p = (it.pa > line_len) ? line_len : it.pa;
        q = (it.pb > line_len) ? line_len : it.pb;
        sel_a = (p > q) ? q : p;
        sel_b = (p > q) ? p : q;
        r.redraw = 1'b1;
      end
      OP_CUT, OP_COPY: begin
        if (s == e) r.status = STATUS_NOP;
        else if (e - s > DEPTH) r.status = STATUS_OVERFLOW;
        else begin
          for (int i = 0; i < e - s; i++) scrap_mem[i] = line_mem[s + i];
          scrap_len = e - s;
          if (it.op == OP_CUT) begin
            replace_range(s, e, 0);
            restart = 1;
            r.redraw = 1'b1;
          end
        end
      end
      OP_PASTE: begin
        if (scrap_len == 0) r.status = STATUS_NOP;
        else if (!room_for(scrap_len)) r.status = STATUS_OVERFLOW;
        else begin
          src_buf = scrap_mem;
          replace_range(s, e, scrap_len);
          restart = 1;
          r.redraw = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (s == e) r.status = STATUS_NOP;
        else begin
          replace_range(s, e, 0);
          restart = 1;
          r.redraw = 1'b1;
        end
      end
      OP_START_LOAD: begin
        line_len = 0; sel_a = 0; sel_b = 0;
        r.redraw = 1'b1;
      end
      OP_LOAD_CHAR: begin
        if (line_len >= DEPTH) r.status = STATUS_OVERFLOW;
        else begin
          line_mem[line_len] = it.ch;
          line_len++;
          sel_a = line_len; sel_b = line_len;
          r.redraw = 1'b1;
        end
      end
      OP_ACTIVATE: begin
        active = 1;
        restart = 1;
        r.redraw = 1'b1;
      end
      OP_DEACTIVATE: begin
        active = 0;
        r.redraw = 1'b1;
      end
      OP_TICK: begin
        if (!active) r.status = STATUS_NOP;
        else begin
          per = (blink_per == 0) ? 1 : blink_per;
          blink_cnt = (blink_cnt + 1) & 8'hFF;
          if (blink_cnt >= per) begin
            caret_vis = ~caret_vis;
            blink_cnt = 0;
            r.redraw = (sel_a == sel_b);
          end
        end
      end
      OP_READ_CHAR: begin
        if (it.pa < line_len) r.rdata = line_mem[it.pa];
      end
      default: r.status = STATUS_NOP;
    endcase
    if (restart) begin
      caret_vis = 1;
      blink_cnt = 0;
    end
    r.len = 9'(line_len);
    r.sfirst = 9'(sel_a);
    r.slast = 9'(sel_b);
    r.caret = caret_vis;
    r.slen = 9'(scrap_len);
    snapshot_q.push_back(r);
  endfunction

  // acceptance and result check at the rising edge
  always @(posedge clk_i) begin
    snapshot_t act, exp_r;
    if (s_axis_tvalid && s_axis_tready) begin
      edit_predict(cur_item);
      sent = 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = 1;
      act = {m_axis_tuser, m_axis_tdata[45:0]};
      act = '{status: m_axis_tuser, rdata: m_axis_tdata[7:0], len: m_axis_tdata[16:8],
              sfirst: m_axis_tdata[25:17], slast: m_axis_tdata[34:26],
              caret: m_axis_tdata[35], redraw: m_axis_tdata[36], slen: m_axis_tdata[45:37]};
      if (snapshot_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, act);
        fail_cnt++;
      end else begin
        exp_r = snapshot_q.pop_front();
        if (act != exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
          fail_cnt++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("single_line_edit_buffer verification failed");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin
    logic valid_n;
    valid_n = s_axis_tvalid;
    if (sent) begin
      sent = 0;
      have_item = 0;
      valid_n = 0;
    end
    if (rst_ni && !have_item && pending_q.size() > 0 &&
        !(pending_q[0].drain && snapshot_q.size() > 0)) begin
      cur_item = pending_q.pop_front();
      gap_cnt = cur_item.gap;
      have_item = 1;
    end
    if (have_item && !valid_n) begin
      if (gap_cnt == 0) begin
        valid_n = 1;
        s_axis_tdata <= {5'b0, cur_item.ext, cur_item.pb, cur_item.pa, cur_item.ch};
        s_axis_tuser <= cur_item.op;
      end else gap_cnt--;
    end
    s_axis_tvalid <= valid_n;
  end

  // long receiver hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end else if (hold_cnt > 0) hold_cnt--;
  end

  // receiver
  always @(negedge clk_i) begin
    if (got) begin
      got = 0;
      rx_wait = $urandom_range(0, stall_max);
    end else if (rx_wait > 0) rx_wait--;
    m_axis_tready <= rst_ni && rx_wait == 0 && hold_cnt == 0;
  end

  function automatic edit_item_t mk(logic [3:0] op, logic [7:0] ch = 0, logic [8:0] pa = 0,
                                    logic [8:0] pb = 0, logic ext = 0);
    edit_item_t it;
    it.op = op; it.ch = ch; it.pa = pa; it.pb = pb; it.ext = ext;
    it.gap = $urandom_range(0, gap_max);
    it.drain = 0;
    return it;
  endfunction

  function automatic edit_item_t rand_item();
    int r, k;
    logic [7:0] ch;
    logic [8:0] pa, pb;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    ch = 8'($urandom_range(0, 255));
    pa = (k < 7) ? 9'($urandom_range(0, 40)) : (k < 9 ? 9'($urandom_range(0, 256)) : 9'd256);
    pb = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 60)) : 9'($urandom_range(0, 511));
    if (r < 30) begin
      k = $urandom_range(0, 9);
      if (k < 2) ch = KEY_BACKSPACE;
      else if (k < 5) ch = KEY_LEFT + 8'($urandom_range(0, 3));
      return mk(OP_KEY, ch, pa, pb, 1'($urandom_range(0, 1)));
    end
    if (r < 40) return mk(OP_CLICK, ch, pa, pb, 1'($urandom_range(0, 1)));
    if (r < 48) return mk(OP_SET_SELECT, ch, pa, pb, 1'($urandom_range(0, 1)));
    if (r < 53) return mk(OP_CUT, ch, pa, pb);
    if (r < 58) return mk(OP_COPY, ch, pa, pb);
    if (r < 66) return mk(OP_PASTE, ch, pa, pb);
    if (r < 70) return mk(OP_CLEAR, ch, pa, pb);
    if (r < 72) return mk(OP_START_LOAD, ch, pa, pb);
    if (r < 80) return mk(OP_LOAD_CHAR, ch, pa, pb);
    if (r < 82) return mk(OP_ACTIVATE, ch, pa, pb);
    if (r < 83) return mk(OP_DEACTIVATE, ch, pa, pb);
    if (r < 92) return mk(OP_TICK, ch, pa, pb);
    if (r < 98) return mk(OP_READ_CHAR, ch, pa, pb, 1'($urandom_range(0, 1)));
    return mk(4'($urandom_range(13, 15)), ch, pa, pb, 1'($urandom_range(0, 1)));
  endfunction

  task automatic settle();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || have_item || snapshot_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_blink(logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    blink_per = v;
  endtask

  initial begin
    logic [7:0] periods[4];
    edit_item_t it;
    line_len = 0; sel_a = 0; sel_b = 0; scrap_len = 0;
    blink_cnt = 0; blink_per = BLINK_RESET; caret_vis = 1; active = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    set_blink(BLINK_RESET);

    // directed
    pending_q.push_back(mk(OP_CUT));
    pending_q.push_back(mk(OP_COPY));
    pending_q.push_back(mk(OP_PASTE));
    pending_q.push_back(mk(OP_CLEAR));
    pending_q.push_back(mk(OP_TICK));
    pending_q.push_back(mk(OP_KEY, KEY_BACKSPACE));
    pending_q.push_back(mk(OP_KEY, 8'hFF));
    pending_q.push_back(mk(OP_KEY, 8'h00));
    pending_q.push_back(mk(OP_LOAD_CHAR, 8'hA5));
    pending_q.push_back(mk(OP_KEY, KEY_LEFT));
    pending_q.push_back(mk(OP_KEY, KEY_RIGHT));
    pending_q.push_back(mk(OP_KEY, KEY_HOME));
    pending_q.push_back(mk(OP_KEY, KEY_END));
    pending_q.push_back(mk(OP_CLICK, 0, 9'd256, 0, 0));
    pending_q.push_back(mk(OP_CLICK, 0, 9'd0, 0, 1));
    pending_q.push_back(mk(OP_CLICK, 0, 9'd2, 0, 1));
    pending_q.push_back(mk(OP_SET_SELECT, 0, 9'd256, 9'd1));
    pending_q.push_back(mk(OP_COPY));
    pending_q.push_back(mk(OP_CUT));
    pending_q.push_back(mk(OP_PASTE));
    pending_q.push_back(mk(OP_READ_CHAR, 0, 9'd1));
    pending_q.push_back(mk(OP_READ_CHAR, 0, 9'd256));
    pending_q.push_back(mk(OP_ACTIVATE));
    pending_q.push_back(mk(OP_DEACTIVATE));
    pending_q.push_back(mk(4'd15, 8'hFF, 9'h1FF, 9'h1FF, 1));
    settle();

    periods = '{8'd1, 8'd255, 8'd3, 8'd0};
    periods[2] = 8'($urandom_range(2, 254));
    for (int ph = 0; ph < 4; ph++) begin
      set_blink(periods[ph]);
      gap_max = (ph == 2) ? 0 : 16;
      stall_max = (ph == 2) ? 0 : 16;
      pending_q.push_back(mk(OP_ACTIVATE));
      if (ph == 1) for (int i = 0; i < 260; i++) pending_q.push_back(mk(OP_TICK));
      // fill the line to the top so inserts overflow
      if (ph == 0) begin
        pending_q.push_back(mk(OP_START_LOAD));
        for (int i = 0; i < 257; i++)
          pending_q.push_back(mk(OP_LOAD_CHAR, 8'($urandom_range(0, 255))));
        pending_q.push_back(mk(OP_KEY, 8'h41));
        pending_q.push_back(mk(OP_SET_SELECT, 0, 9'd0, 9'd256));
        pending_q.push_back(mk(OP_COPY));
        pending_q.push_back(mk(OP_KEY, KEY_RIGHT));
        pending_q.push_back(mk(OP_PASTE));
        pending_q.push_back(mk(OP_START_LOAD));
      end
      for (int i = 0; i < 170; i++) begin
        it = rand_item();
        if (i == 60) it.drain = 1;
        pending_q.push_back(it);
        if (ph == 3 && i == 80) hold_req = 1;
      end
      if (ph == 0) hold_req = 1;
      settle();
    end

    do @(posedge clk_i);
    while (pending_q.size() > 0 || have_item || snapshot_q.size() > 0);
    repeat (600) @(posedge clk_i);
    if (fail_cnt == 0) $display("single_line_edit_buffer verification clean");
    else $display("single_line_edit_buffer verification failed");
    $finish;
  end

endmodule
